@@ sv/imubr_pkg.sv @@
package imubr_pkg;

   localparam int MAX_WINDOW_DEF  = 128;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int CFG_BITS        = 8;
   localparam int VEL_BITS        = 40;
   localparam int POS_BITS        = 56;
   localparam logic [CFG_BITS-1:0] WINDOW_RESET = 8'd100;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_DIV_INIT,
      ST_DIV,
      ST_VEL,
      ST_POS,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic take;
      logic clear;
      logic update;
      logic div_start;
      logic div_step;
      logic vel;
      logic pos;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic req_valid;
      logic out_busy;
   } sts_type;

endpackage

@@ sv/imubr_channels.sv @@
interface imubr_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] accel_x;
   logic signed [SAMPLE_BITS-1:0] accel_y;
   logic signed [SAMPLE_BITS-1:0] accel_z;

   modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
   modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface imubr_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   import imubr_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] bias_x;
   logic signed [SAMPLE_BITS-1:0] bias_y;
   logic signed [SAMPLE_BITS-1:0] bias_z;
   logic signed [SAMPLE_BITS:0]   corrected_x;
   logic signed [SAMPLE_BITS:0]   corrected_y;
   logic signed [SAMPLE_BITS:0]   corrected_z;
   logic signed [VEL_BITS-1:0]    vel_x;
   logic signed [VEL_BITS-1:0]    vel_y;
   logic signed [VEL_BITS-1:0]    vel_z;
   logic signed [POS_BITS-1:0]    pos_x;
   logic signed [POS_BITS-1:0]    pos_y;
   logic signed [POS_BITS-1:0]    pos_z;

   modport source (
      output valid, output bias_x, output bias_y, output bias_z,
      output corrected_x, output corrected_y, output corrected_z,
      output vel_x, output vel_y, output vel_z,
      output pos_x, output pos_y, output pos_z,
      input ready
   );
   modport sink (
      input valid, input bias_x, input bias_y, input bias_z,
      input corrected_x, input corrected_y, input corrected_z,
      input vel_x, input vel_y, input vel_z,
      input pos_x, input pos_y, input pos_z,
      output ready
   );
endinterface

interface imubr_csr_if;
   import imubr_pkg::*;
   logic                valid;
   logic                ready;
   logic [CFG_BITS-1:0] window_len;

   modport source (output valid, output window_len, input ready);
   modport sink   (input valid, input window_len, output ready);
endinterface

@@ sv/imubr_div.sv @@
module imubr_div #(
   parameter int DW = 23,
   parameter int LW = 8
) (
   input  logic                 clock,
   input  logic                 start,
   input  logic                 step,
   input  logic signed [DW-1:0] dividend,
   input  logic        [LW-1:0] divisor,
   output logic signed [DW-1:0] quotient
);
   import imubr_pkg::*;

   logic [DW-1:0] mag_ff, mag_in;
   logic [LW-1:0] rem_ff, rem_in;
   logic [LW-1:0] dvs_ff;
   logic          neg_ff;
   logic [LW:0]   trial;
   logic [LW:0]   diff;
   logic          ge;

   // restoring division, one quotient bit per step
   assign trial = {rem_ff, mag_ff[DW-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      mag_in = mag_ff;
      rem_in = rem_ff;
      if (start) begin
         mag_in = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
         rem_in = '0;
      end else if (step) begin
         mag_in = {mag_ff[DW-2:0], ge};
         rem_in = ge ? diff[LW-1:0] : trial[LW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      if (start) begin
         neg_ff <= dividend[DW-1];
         dvs_ff <= divisor;
      end
   end

   assign quotient = neg_ff ? -$signed(mag_ff) : $signed(mag_ff);

endmodule

@@ sv/imubr_ctrl.sv @@
module imubr_ctrl #(
   parameter int DIV_STEPS = 23
) (
   input  logic               clock,
   input  logic               reset,
   input  imubr_pkg::sts_type sts,
   output imubr_pkg::cmd_type cmd
);
   import imubr_pkg::*;

   localparam int CNTW = $clog2(DIV_STEPS + 1);

   state_type       state_ff, state_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cmd.take = 1'b1;
            if (sts.req_valid) state_in = ST_READ;
         end
         ST_READ: begin
            cmd.update = 1'b1;
            state_in   = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.div_start = 1'b1;
            cnt_in        = '0;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(DIV_STEPS - 1)) state_in = ST_VEL;
         end
         ST_VEL: begin
            cmd.vel  = 1'b1;
            state_in = ST_POS;
         end
         ST_POS: begin
            cmd.pos  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!sts.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule

@@ sv/imubr_dp.sv @@
module imubr_dp #(
   parameter int MAX_WINDOW  = 128,
   parameter int SAMPLE_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  imubr_pkg::cmd_type cmd,
   output imubr_pkg::sts_type sts,
   imubr_req_if.sink          req_ch,
   imubr_rsp_if.source        rsp_ch,
   imubr_csr_if.sink          csr_ch
);
   import imubr_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int LW = $clog2(MAX_WINDOW + 1);
   localparam int SW = SB + IW;
   localparam int CW = (LW > CFG_BITS) ? LW : CFG_BITS;
   localparam int VB = VEL_BITS;
   localparam int PB = POS_BITS;

   logic [CFG_BITS-1:0] window_len_ff;
   logic [CW-1:0]       wl_ext;
   logic [LW-1:0]       len;

   logic [3*SB-1:0] ring_mem [MAX_WINDOW];
   logic [3*SB-1:0] rd_data_ff;
   logic [3*SB-1:0] mem_wdata;
   logic [IW-1:0]   mem_addr;
   logic            mem_we;
   logic [IW-1:0]   clr_addr_ff;

   logic signed [SB-1:0] smp_ff [3];
   logic signed [SW-1:0] sum_ff [3];
   logic signed [SW-1:0] quot   [3];
   logic [IW-1:0]        idx_ff, idx_nxt;
   logic [LW:0]          idx_inc;
   logic                 warm_ff;
   logic                 accept;

   logic signed [SW:0]   corr_w  [3];
   logic signed [VB:0]   vel_sum [3];
   logic signed [PB:0]   pos_sum [3];
   logic signed [VB-1:0] vel_sat [3];
   logic signed [PB-1:0] pos_sat [3];
   logic signed [VB-1:0] vel_ff  [3];
   logic signed [PB-1:0] pos_ff  [3];
   logic signed [SB:0]   corr_ff [3];

   logic                 out_valid_ff;
   logic signed [SB-1:0] o_bias_ff [3];
   logic signed [SB:0]   o_corr_ff [3];
   logic signed [VB-1:0] o_vel_ff  [3];
   logic signed [PB-1:0] o_pos_ff  [3];

   // config register
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= WINDOW_RESET;
      end else if (csr_ch.valid) begin
         window_len_ff <= csr_ch.window_len;
      end
   end

   // effective window length, clamped to 1..MAX_WINDOW
   assign wl_ext = CW'(window_len_ff);

   always_comb begin
      if (wl_ext == '0) begin
         len = LW'(1);
      end else if (wl_ext > CW'(MAX_WINDOW)) begin
         len = LW'(MAX_WINDOW);
      end else begin
         len = LW'(wl_ext);
      end
   end

   // handshake and status
   assign accept         = cmd.take & req_ch.valid;
   assign req_ch.ready   = cmd.take;
   assign sts.req_valid  = req_ch.valid;
   assign sts.clear_done = (clr_addr_ff == IW'(MAX_WINDOW - 1));
   assign sts.out_busy   = out_valid_ff & ~rsp_ch.ready;

   // sample ring, all three axes in one word
   assign mem_we    = cmd.clear | cmd.update;
   assign mem_addr  = cmd.clear ? clr_addr_ff : idx_ff;
   assign mem_wdata = cmd.clear ? '0 : {smp_ff[2], smp_ff[1], smp_ff[0]};

   always_ff @(posedge clock) begin
      if (mem_we) ring_mem[mem_addr] <= mem_wdata;
      if (accept) rd_data_ff <= ring_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= clr_addr_ff + IW'(1);
      end
   end

   // ring index advance and warm-up
   assign idx_inc = (LW+1)'(idx_ff) + (LW+1)'(1);
   assign idx_nxt = (idx_inc < (LW+1)'(len)) ? IW'(idx_inc) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         warm_ff <= 1'b0;
      end else if (cmd.update) begin
         idx_ff <= idx_nxt;
         if (LW'(idx_nxt) == len - LW'(1)) warm_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         smp_ff[0] <= req_ch.accel_x;
         smp_ff[1] <= req_ch.accel_y;
         smp_ff[2] <= req_ch.accel_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) sum_ff[k] <= '0;
      end else if (cmd.update) begin
         for (int k = 0; k < 3; k++) begin
            sum_ff[k] <= sum_ff[k] + SW'(smp_ff[k]) - SW'($signed(rd_data_ff[k*SB +: SB]));
         end
      end
   end

   // bias dividers, one per axis
   for (genvar g = 0; g < 3; g++) begin : g_div
      imubr_div #(
         .DW (SW),
         .LW (LW)
      ) u_div (
         .clock    (clock),
         .start    (cmd.div_start),
         .step     (cmd.div_step),
         .dividend (sum_ff[g]),
         .divisor  (len),
         .quotient (quot[g])
      );
   end

   // saturating integrators
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         corr_w[k]  = (SW+1)'(smp_ff[k]) - (SW+1)'(quot[k]);
         vel_sum[k] = (VB+1)'(vel_ff[k]) + (VB+1)'(corr_w[k]);
         pos_sum[k] = (PB+1)'(pos_ff[k]) + (PB+1)'(vel_ff[k]);
         if (vel_sum[k][VB] != vel_sum[k][VB-1]) begin
            vel_sat[k] = vel_sum[k][VB] ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}};
         end else begin
            vel_sat[k] = vel_sum[k][VB-1:0];
         end
         if (pos_sum[k][PB] != pos_sum[k][PB-1]) begin
            pos_sat[k] = pos_sum[k][PB] ? {1'b1, {(PB-1){1'b0}}} : {1'b0, {(PB-1){1'b1}}};
         end else begin
            pos_sat[k] = pos_sum[k][PB-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            vel_ff[k] <= '0;
            pos_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < 3; k++) begin
            if (cmd.vel && warm_ff) vel_ff[k] <= vel_sat[k];
            if (cmd.pos) pos_ff[k] <= pos_sat[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.vel) begin
         for (int k = 0; k < 3; k++) corr_ff[k] <= corr_w[k][SB:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         for (int k = 0; k < 3; k++) begin
            o_bias_ff[k] <= quot[k][SB-1:0];
            o_corr_ff[k] <= corr_ff[k];
            o_vel_ff[k]  <= vel_ff[k];
            o_pos_ff[k]  <= pos_ff[k];
         end
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.bias_x      = o_bias_ff[0];
   assign rsp_ch.bias_y      = o_bias_ff[1];
   assign rsp_ch.bias_z      = o_bias_ff[2];
   assign rsp_ch.corrected_x = o_corr_ff[0];
   assign rsp_ch.corrected_y = o_corr_ff[1];
   assign rsp_ch.corrected_z = o_corr_ff[2];
   assign rsp_ch.vel_x       = o_vel_ff[0];
   assign rsp_ch.vel_y       = o_vel_ff[1];
   assign rsp_ch.vel_z       = o_vel_ff[2];
   assign rsp_ch.pos_x       = o_pos_ff[0];
   assign rsp_ch.pos_y       = o_pos_ff[1];
   assign rsp_ch.pos_z       = o_pos_ff[2];

endmodule

@@ sv/imu_bias_removal_integrator.sv @@
// Moving-average bias removal and double integration of three-axis
// acceleration samples.
// req_ch carries one sample per beat, rsp_ch one result per beat with the
// bias estimates, corrected samples, velocity and position of all axes.
// csr_ch writes the window length; it is always ready. The user must write it only
// while no sample is in flight; the block itself does not enforce this.
// rsp_ch.valid rises after an accepted sample has passed the ring update,
// the bit-serial bias dividers (one quotient bit per cycle, all three axes
// in parallel), the velocity and position steps and the output register.
// One sample is worked on at a time; the next is not accepted until the
// result of the last has been loaded into the output register.
// Reset: window length returns to 100, integrators and sums clear, and the
// sample ring is swept to zero, one entry a cycle, during which req_ch.ready
// stays low.
// A result waits in the output register while the receiver stalls; the
// next sample is accepted and worked on meanwhile, and its result is held
// back until the register is free.
module imu_bias_removal_integrator #(
   parameter int MAX_WINDOW  = imubr_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = imubr_pkg::SAMPLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   imubr_req_if.sink   req_ch,
   imubr_rsp_if.source rsp_ch,
   imubr_csr_if.sink   csr_ch
);
   import imubr_pkg::*;

   localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   cmd_type cmd;
   sts_type sts;

   imubr_ctrl #(
      .DIV_STEPS (SAMPLE_BITS + IW)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   imubr_dp #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .sts    (sts),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import imubr_pkg::*;

   typedef struct packed {
      logic signed [15:0]         bias_x;
      logic signed [15:0]         bias_y;
      logic signed [15:0]         bias_z;
      logic signed [16:0]         corrected_x;
      logic signed [16:0]         corrected_y;
      logic signed [16:0]         corrected_z;
      logic signed [VEL_BITS-1:0] vel_x;
      logic signed [VEL_BITS-1:0] vel_y;
      logic signed [VEL_BITS-1:0] vel_z;
      logic signed [POS_BITS-1:0] pos_x;
      logic signed [POS_BITS-1:0] pos_y;
      logic signed [POS_BITS-1:0] pos_z;
   } motion_type;

   typedef struct {
      bit                  set_len;
      logic [CFG_BITS-1:0] len_val;
      logic signed [15:0]  ax;
      logic signed [15:0]  ay;
      logic signed [15:0]  az;
      bit                  typed;
      motion_type          want;
   } sample_row_type;

   logic clock;
   logic reset;

   imubr_req_if #(.SAMPLE_BITS(16)) req_if ();
   imubr_rsp_if #(.SAMPLE_BITS(16)) rsp_if ();
   imubr_csr_if                     csr_if ();

   imu_bias_removal_integrator u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // mirror of the block state
   logic signed [15:0]  ring [3][128];
   longint              win_sum [3];
   int                  ring_pos;
   bit                  warm;
   longint              vel_acc [3];
   longint              pos_acc [3];
   logic [CFG_BITS-1:0] win_len_cfg;

   motion_type motion_q [$];
   int         n_errors = 0;
   int         burst_left = 0;
   bit         hold_req = 0;
   bit         hold_done = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12_000_000);
      $display("Test completed with failures");
      $finish;
   end

   function automatic longint clamp_add(longint a, longint b, int bits);
      longint hi;
      longint lo;
      longint s;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      s = a + b;
      if (s > hi) return hi;
      if (s < lo) return lo;
      return s;
   endfunction

   function automatic motion_type integrate_sample(input logic signed [15:0] ax,
                                                   input logic signed [15:0] ay,
                                                   input logic signed [15:0] az);
      longint     smp [3];
      longint     quo [3];
      longint     corr [3];
      int         len;
      int         slot;
      motion_type r;
      smp[0] = longint'(ax);
      smp[1] = longint'(ay);
      smp[2] = longint'(az);
      len = int'(win_len_cfg);
      if (len < 1) len = 1;
      if (len > 128) len = 128;
      slot = (ring_pos >= 128) ? 0 : ring_pos;
      for (int k = 0; k < 3; k++) begin
         win_sum[k] += smp[k] - longint'(ring[k][slot]);
         ring[k][slot] = smp[k][15:0];
      end
      ring_pos = (slot + 1 < len) ? slot + 1 : 0;
      if (!warm && ring_pos == len - 1) warm = 1'b1;
      for (int k = 0; k < 3; k++) begin
         quo[k] = win_sum[k] / longint'(len);
         corr[k] = smp[k] - quo[k];
         if (warm) vel_acc[k] = clamp_add(vel_acc[k], corr[k], VEL_BITS);
         pos_acc[k] = clamp_add(pos_acc[k], vel_acc[k], POS_BITS);
      end
      r.bias_x = 16'(quo[0]);
      r.bias_y = 16'(quo[1]);
      r.bias_z = 16'(quo[2]);
      r.corrected_x = 17'(corr[0]);
      r.corrected_y = 17'(corr[1]);
      r.corrected_z = 17'(corr[2]);
      r.vel_x = VEL_BITS'(vel_acc[0]);
      r.vel_y = VEL_BITS'(vel_acc[1]);
      r.vel_z = VEL_BITS'(vel_acc[2]);
      r.pos_x = POS_BITS'(pos_acc[0]);
      r.pos_y = POS_BITS'(pos_acc[1]);
      r.pos_z = POS_BITS'(pos_acc[2]);
      return r;
   endfunction

   function automatic sample_row_type mk_row(int set_len, int len_val, int ax, int ay, int az);
      sample_row_type row;
      row.set_len = set_len[0];
      row.len_val = len_val[CFG_BITS-1:0];
      row.ax = ax[15:0];
      row.ay = ay[15:0];
      row.az = az[15:0];
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   function automatic logic signed [15:0] pick_axis(int sel, int center);
      int v;
      if (sel < 60) begin
         v = center + $urandom_range(0, 1024) - 512;
      end else if (sel < 85) begin
         v = $urandom;
      end else begin
         case ($urandom_range(0, 3))
            0: v = -32768;
            1: v = 32767;
            2: v = 0;
            default: v = -1;
         endcase
      end
      return v[15:0];
   endfunction

   function automatic void check_field(string fname, logic signed [63:0] want,
                                       logic signed [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, fname, want, got);
         n_errors++;
      end
   endfunction

   task automatic offer_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
                               input logic signed [15:0] az, output motion_type predicted);
      req_if.valid   <= 1'b1;
      req_if.accel_x <= ax;
      req_if.accel_y <= ay;
      req_if.accel_z <= az;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted = integrate_sample(ax, ay, az);
   endtask

   task automatic sender_idle();
      int gap;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // the block must be idle before the window length changes
   task automatic write_window(input logic [CFG_BITS-1:0] v);
      req_if.valid <= 1'b0;
      wait (motion_q.size() == 0);
      @(posedge clock);
      csr_if.valid      <= 1'b1;
      csr_if.window_len <= v;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      win_len_cfg = v;
   endtask

   // result beats
   always @(posedge clock) begin
      motion_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (motion_q.size() == 0) begin
            $display("%0t: result beat with nothing pending", $time);
            n_errors++;
         end else begin
            want = motion_q.pop_front();
            check_field("bias_x", 64'(want.bias_x), 64'(rsp_if.bias_x));
            check_field("bias_y", 64'(want.bias_y), 64'(rsp_if.bias_y));
            check_field("bias_z", 64'(want.bias_z), 64'(rsp_if.bias_z));
            check_field("corrected_x", 64'(want.corrected_x), 64'(rsp_if.corrected_x));
            check_field("corrected_y", 64'(want.corrected_y), 64'(rsp_if.corrected_y));
            check_field("corrected_z", 64'(want.corrected_z), 64'(rsp_if.corrected_z));
            check_field("vel_x", 64'(want.vel_x), 64'(rsp_if.vel_x));
            check_field("vel_y", 64'(want.vel_y), 64'(rsp_if.vel_y));
            check_field("vel_z", 64'(want.vel_z), 64'(rsp_if.vel_z));
            check_field("pos_x", 64'(want.pos_x), 64'(rsp_if.pos_x));
            check_field("pos_y", 64'(want.pos_y), 64'(rsp_if.pos_y));
            check_field("pos_z", 64'(want.pos_z), 64'(rsp_if.pos_z));
         end
      end
   end

   // receiver stall pattern
   initial begin
      int seg_left;
      int mode;
      int cyc;
      seg_left = 0;
      mode = 0;
      cyc = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         if (seg_left == 0) begin
            seg_left = $urandom_range(50, 400);
            mode = $urandom_range(0, 3);
         end
         seg_left--;
         cyc++;
         case (mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_if.ready <= ((cyc % 7) < 3);
         endcase
      end
   end

   initial begin
      sample_row_type      sample_tab [$];
      sample_row_type      row;
      motion_type          predicted;
      int                  n_random;
      int                  phase;
      int                  plen;
      int                  pick;
      int                  sel;
      int                  center [3];
      logic [CFG_BITS-1:0] wl;

      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 128; i++) ring[k][i] = '0;
         win_sum[k] = 0;
         vel_acc[k] = 0;
         pos_acc[k] = 0;
      end
      ring_pos = 0;
      warm = 1'b0;
      win_len_cfg = WINDOW_RESET;

      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.accel_x    <= '0;
      req_if.accel_y    <= '0;
      req_if.accel_z    <= '0;
      csr_if.valid      <= 1'b0;
      csr_if.window_len <= '0;

      // first two beats after reset, window of 100, still warming up
      row = mk_row(0, 0, 0, 0, 0);
      row.typed = 1'b1;
      sample_tab.push_back(row);
      row = mk_row(0, 0, 32767, -32768, 1);
      row.typed = 1'b1;
      row.want.bias_x = 16'(327);
      row.want.bias_y = 16'(-327);
      row.want.bias_z = '0;
      row.want.corrected_x = 17'(32440);
      row.want.corrected_y = 17'(-32441);
      row.want.corrected_z = 17'(1);
      sample_tab.push_back(row);
      // index beyond the shrunk window, then zero, full, oversized and small window lengths
      sample_tab.push_back(mk_row(1, 1, -32768, 32767, -1));
      sample_tab.push_back(mk_row(0, 0, 100, 200, -300));
      sample_tab.push_back(mk_row(1, 0, 32767, 32767, 32767));
      sample_tab.push_back(mk_row(0, 0, -32768, -32768, -32768));
      sample_tab.push_back(mk_row(1, 128, -32768, -32768, -32768));
      sample_tab.push_back(mk_row(0, 0, -32768, -32768, -32768));
      sample_tab.push_back(mk_row(0, 0, 32767, -32768, 0));
      sample_tab.push_back(mk_row(1, 255, 32767, 32767, 32767));
      sample_tab.push_back(mk_row(0, 0, -1, -1, -1));
      sample_tab.push_back(mk_row(1, 2, -32768, -32768, -32768));
      sample_tab.push_back(mk_row(0, 0, -32768, -32768, -32768));
      sample_tab.push_back(mk_row(0, 0, 32767, 32767, 32767));
      sample_tab.push_back(mk_row(0, 0, 32767, 32767, 32767));
      sample_tab.push_back(mk_row(0, 0, -32768, -32768, -32768));
      sample_tab.push_back(mk_row(1, 3, 12345, -12345, 0));
      sample_tab.push_back(mk_row(0, 0, 21845, -21846, 1));
      sample_tab.push_back(mk_row(0, 0, -21846, 21845, -2));
      sample_tab.push_back(mk_row(1, 100, 0, 0, 0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < sample_tab.size(); i++) begin
         if (sample_tab[i].set_len) write_window(sample_tab[i].len_val);
         offer_sample(sample_tab[i].ax, sample_tab[i].ay, sample_tab[i].az, predicted);
         motion_q.push_back(sample_tab[i].typed ? sample_tab[i].want : predicted);
         if (i + 1 < sample_tab.size() && !sample_tab[i + 1].set_len) sender_idle();
      end

      n_random = 0;
      phase = 0;
      while (n_random < 2000) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: wl = '0;
            1: wl = CFG_BITS'(1);
            2: wl = CFG_BITS'(128);
            3: wl = CFG_BITS'($urandom_range(129, 255));
            4, 5: wl = CFG_BITS'($urandom_range(2, 8));
            default: wl = CFG_BITS'($urandom_range(2, 128));
         endcase
         write_window(wl);
         plen = (phase == 2) ? 60 : $urandom_range(20, 150);
         for (int k = 0; k < 3; k++) center[k] = $urandom_range(0, 16000) - 8000;
         for (int j = 0; j < plen; j++) begin
            sel = $urandom_range(0, 99);
            offer_sample(pick_axis(sel, center[0]), pick_axis(sel, center[1]),
                         pick_axis(sel, center[2]), predicted);
            motion_q.push_back(predicted);
            n_random++;
            // long receiver hold-off while beats keep coming
            if (phase == 2 && j == 1) hold_req = 1'b1;
            if (j + 1 < plen) sender_idle();
         end
         phase++;
      end

      req_if.valid <= 1'b0;
      wait (motion_q.size() == 0);
      repeat (64) @(posedge clock);
      if (n_errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ imu_bias_removal_integrator.f @@
sv/imubr_pkg.sv
sv/imubr_channels.sv
sv/imubr_div.sv
sv/imubr_ctrl.sv
sv/imubr_dp.sv
sv/imu_bias_removal_integrator.sv
test/tb_top.sv
